// ===== rtl/tli_pkg.sv =====
// shared types and constants of the table linear interpolator
package tli_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int CFG_W = 11;
    localparam int NUM_SAMPLES_RST = 1024;
    localparam int ADDR_MAX_W = 16;
    localparam int MID_QUEUE_DEPTH = 4;
    localparam int OUT_QUEUE_DEPTH = 2;

    localparam logic MODE_WRITE = 1'b0;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_CLAMP = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef enum logic [1:0] {
        K_WRITE,
        K_INTERP,
        K_DIRECT
    } t_kind;

    typedef struct packed {
        logic               mode;
        logic [9:0]         entry_index;
        logic [31:0]        entry_time;
        logic signed [31:0] entry_value;
        logic [31:0]        query_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        t_kind                   kind;
        logic [ADDR_MAX_W-1:0]   addr;
        logic [31:0]             tm;
        logic [31:0]             wval;
        logic [31:0]             sp;
        logic [1:0]              status;
    } t_qitem;

endpackage

// ===== rtl/tli_fifo.sv =====
// small register queue used between the pipeline parts and at the output
module tli_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/tli_front.sv =====
// front part: accepts beats, keeps spacing and entry count, finds the base index
module tli_front #(
    parameter int DEPTH = tli_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tli_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       i_push,
    output logic                       o_full,
    input  tli_pkg::t_in_item          i_item,
    output logic                       o_q_push,
    output tli_pkg::t_qitem            o_q_item,
    input  logic                       i_q_full
);
    import tli_pkg::*;

    localparam int NW = $clog2(DEPTH + 1);
    localparam int DIVB = 33;
    localparam int N_RST = (NUM_SAMPLES_RST > DEPTH) ? DEPTH : NUM_SAMPLES_RST;

    logic [NW-1:0]  r_n;
    logic [NW-1:0]  r_last;
    logic [31:0]    r_t0;
    logic [31:0]    r_t1;
    logic [31:0]    r_sp;

    logic           r_fv   [0:DIVB];
    t_qitem         r_fm   [0:DIVB];
    logic [32:0]    r_frem [0:DIVB];
    logic [32:0]    r_fnum [0:DIVB];
    logic [32:0]    r_fdiv [0:DIVB];
    logic [32:0]    r_fq   [0:DIVB];

    logic           fe;
    logic           accept;
    logic           idx_ok;
    logic [32:0]    twice;
    logic           use_div;
    t_qitem         n_m0;
    logic [NW-1:0]  n_n;
    t_qitem         cls;

    assign fe       = !r_fv[DIVB] || !i_q_full;
    assign o_full   = !fe;
    assign accept   = i_push && fe;
    assign idx_ok   = 32'(i_item.entry_index) < DEPTH;
    assign twice    = {i_item.query_time, 1'b0};
    assign use_div  = !r_sp[31] && (r_sp != '0) && (twice >= {1'b0, r_sp});

    always_comb begin
        if (32'(i_cfg_wdata) < 2) begin
            n_n = NW'(2);
        end else if (32'(i_cfg_wdata) > DEPTH) begin
            n_n = NW'(DEPTH);
        end else begin
            n_n = NW'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= NW'(N_RST);
            r_last <= NW'(N_RST - 1);
        end else if (i_cfg_we) begin
            r_n    <= n_n;
            r_last <= n_n - 1'b1;
        end
    end

    // spacing shadow of entries 0 and 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0 <= '0;
            r_t1 <= '0;
            r_sp <= '0;
        end else if (accept && i_item.mode == MODE_WRITE) begin
            if (i_item.entry_index == 10'd0) begin
                r_t0 <= i_item.entry_time;
                r_sp <= r_t1 - i_item.entry_time;
            end else if (i_item.entry_index == 10'd1) begin
                r_t1 <= i_item.entry_time;
                r_sp <= i_item.entry_time - r_t0;
            end
        end
    end

    always_comb begin
        n_m0.addr   = ADDR_MAX_W'(i_item.entry_index);
        n_m0.tm     = i_item.entry_time;
        n_m0.wval   = i_item.entry_value;
        n_m0.sp     = r_sp;
        n_m0.status = ST_OK;
        n_m0.kind   = K_WRITE;
        if (i_item.mode != MODE_WRITE) begin
            n_m0.tm = i_item.query_time;
            if (r_sp == '0) begin
                n_m0.kind   = K_DIRECT;
                n_m0.addr   = ADDR_MAX_W'(r_last);
                n_m0.status = ST_ZERO;
            end else begin
                n_m0.kind = K_INTERP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv[0] <= 1'b0;
        end else if (fe) begin
            r_fv[0] <= accept && (i_item.mode != MODE_WRITE || idx_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe) begin
            r_fm[0]   <= n_m0;
            r_frem[0] <= '0;
            r_fnum[0] <= use_div ? twice - {1'b0, r_sp} : '0;
            r_fdiv[0] <= use_div ? {r_sp, 1'b0} : 33'd1;
            r_fq[0]   <= '0;
        end
    end

    for (genvar k = 0; k < DIVB; k++) begin : g_div
        logic [33:0] cand;
        logic        ge;
        assign cand = {r_frem[k], r_fnum[k][32]};
        assign ge   = cand >= {1'b0, r_fdiv[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fv[k+1] <= 1'b0;
            end else if (fe) begin
                r_fv[k+1] <= r_fv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (fe) begin
                r_fm[k+1]   <= r_fm[k];
                r_frem[k+1] <= ge ? 33'(cand - {1'b0, r_fdiv[k]}) : cand[32:0];
                r_fnum[k+1] <= {r_fnum[k][31:0], 1'b0};
                r_fdiv[k+1] <= r_fdiv[k];
                r_fq[k+1]   <= {r_fq[k][31:0], ge};
            end
        end
    end

    always_comb begin
        cls = r_fm[DIVB];
        if (cls.kind == K_INTERP) begin
            if (r_fq[DIVB] >= 33'(r_n)) begin
                cls.kind   = K_DIRECT;
                cls.addr   = ADDR_MAX_W'(r_last);
                cls.status = ST_CLAMP;
            end else if (r_fq[DIVB] >= 33'(r_last)) begin
                cls.kind = K_DIRECT;
                cls.addr = ADDR_MAX_W'(r_last);
            end else begin
                cls.addr = ADDR_MAX_W'(r_fq[DIVB]);
            end
        end
    end

    assign o_q_push = r_fv[DIVB] && !i_q_full;
    assign o_q_item = cls;

endmodule

// ===== rtl/tli_back.sv =====
// back part: table memories, products, sum and quotient, saturation
module tli_back #(
    parameter int DEPTH = tli_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  tli_pkg::t_qitem    i_q_item,
    output logic               o_q_pop,
    output logic               o_out_push,
    output tli_pkg::t_out_item o_out_item,
    input  logic               i_out_full
);
    import tli_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int QB = 32;

    typedef struct packed {
        logic        direct;
        logic [1:0]  status;
        logic [31:0] dval;
        logic        sneg;
        logic [31:0] spm;
        logic        ovf;
    } t_dmeta;

    logic [31:0]    r_tmem [DEPTH];
    logic [31:0]    r_vmem [DEPTH];

    logic           be;
    logic           pop;
    logic [AW-1:0]  ra;
    logic [AW-1:0]  rb;

    logic           r_v1;
    t_qitem         r_m1;
    logic [31:0]    r_ta;
    logic [31:0]    r_va;
    logic [31:0]    r_tb;
    logic [31:0]    r_vb;

    logic           r_v2;
    t_dmeta         r_m2;
    logic [31:0]    r_dm1;
    logic [31:0]    r_xm1;
    logic           r_n1;
    logic [31:0]    r_dm2;
    logic [31:0]    r_xm2;
    logic           r_n2;

    logic           r_v3;
    t_dmeta         r_m3;
    logic [63:0]    r_p1;
    logic [63:0]    r_p2;
    logic           r_n13;
    logic           r_n23;

    logic           r_v4;
    t_dmeta         r_m4;
    logic [64:0]    r_sum;
    logic           r_rneg4;

    logic           r_dv   [0:QB];
    t_dmeta         r_dmt  [0:QB];
    logic           r_drn  [0:QB];
    logic [31:0]    r_drem [0:QB];
    logic [31:0]    r_dnum [0:QB];
    logic [31:0]    r_dq   [0:QB];

    logic           dneg1;
    logic           dneg2;
    logic [31:0]    n_sp;
    logic [64:0]    n_sum;
    logic           n_rneg;
    t_dmeta         n_m4;
    logic           neg;
    t_out_item      res;

    assign be      = !r_dv[QB] || !i_out_full;
    assign pop     = be && !i_q_empty;
    assign o_q_pop = pop;
    assign ra      = i_q_item.addr[AW-1:0];
    assign rb      = ra + 1'b1;

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (i_q_item.kind == K_WRITE) begin
                r_tmem[ra] <= i_q_item.tm;
                r_vmem[ra] <= i_q_item.wval;
            end else begin
                r_ta <= r_tmem[ra];
                r_va <= r_vmem[ra];
                r_tb <= r_tmem[rb];
                r_vb <= r_vmem[rb];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (be) begin
            r_v1 <= pop && i_q_item.kind != K_WRITE;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // signed differences and sample magnitudes
    assign dneg1 = r_tb < r_m1.tm;
    assign dneg2 = r_m1.tm < r_ta;
    assign n_sp  = r_m1.sp;

    always_ff @(posedge i_clk) begin
        if (be) begin
            if (pop) begin
                r_m1 <= i_q_item;
            end
            r_dm1       <= dneg1 ? r_m1.tm - r_tb : r_tb - r_m1.tm;
            r_xm1       <= r_va[31] ? 32'(0 - r_va) : r_va;
            r_n1        <= dneg1 ^ r_va[31];
            r_dm2       <= dneg2 ? r_ta - r_m1.tm : r_m1.tm - r_ta;
            r_xm2       <= r_vb[31] ? 32'(0 - r_vb) : r_vb;
            r_n2        <= dneg2 ^ r_vb[31];
            r_m2.direct <= r_m1.kind == K_DIRECT;
            r_m2.status <= r_m1.status;
            r_m2.dval   <= r_va;
            r_m2.sneg   <= n_sp[31];
            r_m2.spm    <= n_sp[31] ? 32'(0 - n_sp) : n_sp;
            r_m2.ovf    <= 1'b0;
            r_p1        <= 64'(r_dm1) * 64'(r_xm1);
            r_p2        <= 64'(r_dm2) * 64'(r_xm2);
            r_n13       <= r_n1;
            r_n23       <= r_n2;
            r_m3        <= r_m2;
            r_sum       <= n_sum;
            r_rneg4     <= n_rneg;
            r_m4        <= r_m3;
        end
    end

    always_comb begin
        if (r_n13 == r_n23) begin
            n_sum  = {1'b0, r_p1} + {1'b0, r_p2};
            n_rneg = r_n13;
        end else if (r_p1 >= r_p2) begin
            n_sum  = {1'b0, r_p1 - r_p2};
            n_rneg = r_n13;
        end else begin
            n_sum  = {1'b0, r_p2 - r_p1};
            n_rneg = r_n23;
        end
    end

    always_comb begin
        n_m4     = r_m4;
        n_m4.ovf = r_sum >= {1'b0, r_m4.spm, 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (be) begin
            r_dv[0] <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (be) begin
            r_dmt[0]  <= n_m4;
            r_drn[0]  <= r_rneg4;
            r_drem[0] <= r_sum[63:32];
            r_dnum[0] <= r_sum[31:0];
            r_dq[0]   <= '0;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [32:0] cand;
        logic        ge;
        assign cand = {r_drem[k], r_dnum[k][31]};
        assign ge   = cand >= {1'b0, r_dmt[k].spm};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (be) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (be) begin
                r_dmt[k+1]  <= r_dmt[k];
                r_drn[k+1]  <= r_drn[k];
                r_drem[k+1] <= ge ? 32'(cand - {1'b0, r_dmt[k].spm}) : cand[31:0];
                r_dnum[k+1] <= {r_dnum[k][30:0], 1'b0};
                r_dq[k+1]   <= {r_dq[k][30:0], ge};
            end
        end
    end

    // sign and saturation
    always_comb begin
        neg        = (r_drn[QB] && r_dq[QB] != '0) != r_dmt[QB].sneg;
        res.status = r_dmt[QB].status;
        if (r_dmt[QB].direct) begin
            res.value = r_dmt[QB].dval;
        end else if (neg) begin
            res.value = (r_dmt[QB].ovf || r_dq[QB][31]) ? 32'h8000_0000 : 32'(0 - r_dq[QB]);
        end else begin
            res.value = (r_dmt[QB].ovf || r_dq[QB][31]) ? 32'h7FFF_FFFF : r_dq[QB];
        end
    end

    assign o_out_push = r_dv[QB] && !i_out_full;
    assign o_out_item = res;

endmodule

// ===== rtl/table_linear_interpolator.sv =====
// top level of the table linear interpolator
// Takes one beat per cycle while full is low, writes and queries alike, and delivers one result
// per query in order. A query passes through the front part (one input register plus one per
// bit of the 33-bit base index division), the middle queue, the back part (memory read,
// magnitudes, products, sum, divider load, and one per bit of the 32-bit quotient) and the
// output queue; a stalled output holds the whole pipeline. The table memories have no
// reset and no clearing pass: entries must be written before a query reads them. The user
// must write the entry count register only while the block is idle; the block itself
// does not enforce this.
module table_linear_interpolator #(
    parameter int DEPTH = tli_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tli_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                       push,
    output logic                       full,
    input  tli_pkg::t_in_item          i_item,
    output logic                       empty,
    input  logic                       pop,
    output tli_pkg::t_out_item         o_result
);
    import tli_pkg::*;

    logic       q_push;
    logic       q_full;
    t_qitem     q_in;
    logic       q_pop;
    logic       q_empty;
    t_qitem     q_out;
    logic       out_push;
    logic       out_full;
    t_out_item  out_item;

    tli_front #(.DEPTH(DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_q_push    (q_push),
        .o_q_item    (q_in),
        .i_q_full    (q_full)
    );

    tli_fifo #(.T(t_qitem), .DEPTH(MID_QUEUE_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    tli_back #(.DEPTH(DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_item   (q_out),
        .o_q_pop    (q_pop),
        .o_out_push (out_push),
        .o_out_item (out_item),
        .i_out_full (out_full)
    );

    tli_fifo #(.T(t_out_item), .DEPTH(OUT_QUEUE_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_item),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

// ===== test/tb_table_linear_interpolator.sv =====
// testbench for table_linear_interpolator: queued stimulus, local predictor, in-order checks
`timescale 1ns / 100ps

module tb_table_linear_interpolator;

    import tli_pkg::*;

    localparam logic MODE_QUERY = ~MODE_WRITE;
    localparam int SETTLE_CYCLES = 200;
    localparam int TAIL_CYCLES = 200;

    typedef enum logic {
        OP_BEAT,
        OP_CFG
    } t_op_kind;

    typedef struct {
        t_op_kind        kind;
        t_in_item        item;
        logic [CFG_W-1:0] cfg;
    } t_op;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic             push;
    logic             full;
    t_in_item         i_item;
    logic             empty;
    logic             pop;
    t_out_item        o_result;

    t_op       pend_ops[$];
    t_out_item expected_results[$];

    bit [31:0]        time_tbl[DEPTH_DEF];
    bit [31:0]        value_tbl[DEPTH_DEF];
    bit [31:0]        span;
    bit [CFG_W-1:0]   used_cfg;

    bit took;
    bit stim_done;
    bit calm_tx;
    bit calm_rx;
    int tx_gap;
    int rx_gap;
    int settle;
    int errors;

    table_linear_interpolator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    // magnitude of (hi - lo) * x with its sign
    function automatic bit [63:0] scaled_diff(bit [31:0] hi, bit [31:0] lo, bit [31:0] x,
                                              output bit neg);
        bit        dneg;
        bit [31:0] d;
        bit [31:0] xm;
        bit [63:0] dm;
        dneg = hi < lo;
        d = dneg ? lo - hi : hi - lo;
        xm = x[31] ? 32'd0 - x : x;
        neg = dneg != x[31];
        dm = {32'd0, d};
        return dm * {32'd0, xm};
    endfunction

    function automatic t_out_item interpolate(bit [31:0] t);
        t_out_item r;
        int        n;
        int        last;
        bit        sneg;
        bit        n1;
        bit        n2;
        bit        rneg;
        bit [31:0] spm;
        bit [63:0] b;
        bit [63:0] tw;
        bit [63:0] sp64;
        bit [63:0] p1;
        bit [63:0] p2;
        bit [63:0] sum;
        bit [63:0] q;
        n = used_cfg < 2 ? 2 : (used_cfg > DEPTH_DEF ? DEPTH_DEF : int'(used_cfg));
        last = n - 1;
        r.status = ST_OK;
        if (span == 32'd0) begin
            r.value = value_tbl[last];
            r.status = ST_ZERO;
            return r;
        end
        sneg = span[31];
        spm = sneg ? 32'd0 - span : span;
        sp64 = {32'd0, span};
        b = 64'd0;
        if (!sneg) begin
            tw = {31'd0, t, 1'b0};
            if (tw >= sp64) begin
                b = (tw - sp64) / (sp64 << 1);
            end
        end
        if (b >= 64'(n)) begin
            b = 64'(last);
            r.status = ST_CLAMP;
        end
        if (b >= 64'(last)) begin
            r.value = value_tbl[last];
            return r;
        end
        p1 = scaled_diff(time_tbl[b + 1], t, value_tbl[b], n1);
        p2 = scaled_diff(t, time_tbl[b], value_tbl[b + 1], n2);
        if (n1 == n2) begin
            sum = p1 + p2;
            rneg = n1;
        end else if (p1 >= p2) begin
            sum = p1 - p2;
            rneg = n1;
        end else begin
            sum = p2 - p1;
            rneg = n2;
        end
        q = sum / {32'd0, spm};
        if (q == 64'd0) begin
            rneg = 1'b0;
        end
        if (rneg != sneg) begin
            r.value = q >= 64'h8000_0000 ? 32'h8000_0000 : 32'd0 - q[31:0];
        end else begin
            r.value = q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
        end
        return r;
    endfunction

    task automatic add_write(int idx, bit [31:0] tm, bit [31:0] val);
        t_op op;
        op.kind = OP_BEAT;
        op.cfg = '0;
        op.item = '0;
        op.item.mode = MODE_WRITE;
        op.item.entry_index = idx[9:0];
        op.item.entry_time = tm;
        op.item.entry_value = val;
        op.item.query_time = $urandom;
        pend_ops.push_back(op);
    endtask

    task automatic add_query(bit [31:0] t);
        t_op op;
        op.kind = OP_BEAT;
        op.cfg = '0;
        op.item = '0;
        op.item.mode = MODE_QUERY;
        op.item.entry_index = 10'($urandom);
        op.item.entry_time = $urandom;
        op.item.entry_value = $urandom;
        op.item.query_time = t;
        pend_ops.push_back(op);
    endtask

    task automatic add_cfg(bit [CFG_W-1:0] v);
        t_op op;
        op.kind = OP_CFG;
        op.item = '0;
        op.cfg = v;
        pend_ops.push_back(op);
    endtask

    initial begin
        int          n_eff;
        int          idx;
        bit [31:0]   sp;
        bit [CFG_W-1:0] cfgs[7];
        i_rst_n = 1'b0;
        used_cfg = CFG_W'(NUM_SAMPLES_RST);
        span = 32'd0;

        add_cfg(CFG_W'(1024));
        for (int i = 0; i < DEPTH_DEF; i++) begin
            add_write(i, i << 16, i == DEPTH_DEF - 1 ? 32'h7FFF_FFFF : $urandom);
        end

        // edge cases on the unit grid
        add_query(32'd0);
        add_query(32'hFFFF_FFFF);
        add_query((1023 << 16) + 32'h8000);
        add_query((1022 << 16) + 32'hA000);
        add_write(5, 5 << 16, 32'h7FFF_FFFF);
        add_write(6, 6 << 16, 32'h8000_0000);
        add_query((5 << 16) + 32'hC000);
        add_write(4, 32'hFFFF_0000, 32'h7FFF_FFFF);
        add_query((3 << 16) + 32'h9000);
        add_write(3, 3 << 16, 32'h8000_0000);
        add_query((3 << 16) + 32'h9000);
        add_write(4, 4 << 16, 32'd0);
        add_write(3, 3 << 16, 32'd0);
        add_write(1, 32'd0, 32'd1);
        add_query(32'h0001_2345);
        add_write(0, 32'h0002_0000, 32'h7FFF_FFFF);
        add_query(32'h0000_8000);
        add_query(32'hFFFF_FFFF);
        add_write(0, 32'd0, $urandom);
        add_write(1, 1 << 16, $urandom);
        add_query(32'h0000_8000);

        cfgs[0] = CFG_W'(2);
        cfgs[1] = CFG_W'(0);
        cfgs[2] = CFG_W'($urandom_range(3, 40));
        cfgs[3] = CFG_W'(2047);
        cfgs[4] = CFG_W'(1);
        cfgs[5] = CFG_W'($urandom_range(41, 300));
        cfgs[6] = CFG_W'(1024);
        foreach (cfgs[p]) begin
            add_cfg(cfgs[p]);
            n_eff = cfgs[p] < 2 ? 2 : (cfgs[p] > DEPTH_DEF ? DEPTH_DEF : int'(cfgs[p]));
            sp = $urandom_range(0, 3) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 32'h40000);
            add_write(0, 32'd0, $urandom);
            add_write(1, sp, $urandom);
            for (int k = 0; k < 60; k++) begin
                if ($urandom_range(0, 99) < 80) begin
                    if ($urandom_range(0, 2) == 0) begin
                        idx = $urandom_range(2, n_eff - 1 < 2 ? 2 : n_eff - 1);
                        add_write(idx, idx * sp + $urandom_range(0, sp >> 2), $urandom);
                    end else begin
                        add_query($urandom_range(0, (n_eff + 1) * sp));
                    end
                end else if ($urandom_range(0, 1) == 0) begin
                    add_write($urandom_range(0, DEPTH_DEF - 1), $urandom, $urandom);
                end else begin
                    add_query($urandom);
                end
            end
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver
    always @(negedge i_clk) begin
        logic             push_n;
        logic             pop_n;
        logic             we_n;
        logic [CFG_W-1:0] wd_n;
        t_in_item         item_n;
        push_n = push;
        pop_n = pop;
        we_n = 1'b0;
        wd_n = i_cfg_wdata;
        item_n = i_item;
        if (i_rst_n) begin
            if (!(push && !took)) begin
                if (tx_gap > 0) begin
                    push_n = 1'b0;
                    tx_gap--;
                end else if (pend_ops.size() == 0) begin
                    push_n = 1'b0;
                    stim_done = 1'b1;
                end else if (pend_ops[0].kind == OP_BEAT) begin
                    push_n = 1'b1;
                    item_n = pend_ops[0].item;
                    void'(pend_ops.pop_front());
                    tx_gap = pick_gap(calm_tx);
                    if ($urandom_range(0, 99) == 0) begin
                        calm_tx = !calm_tx;
                    end
                end else begin
                    push_n = 1'b0;
                    if (expected_results.size() != 0) begin
                        settle = 0;
                    end else if (settle < SETTLE_CYCLES) begin
                        settle++;
                    end else begin
                        we_n = 1'b1;
                        wd_n = pend_ops[0].cfg;
                        void'(pend_ops.pop_front());
                        settle = 0;
                    end
                end
            end
            if (rx_gap > 0) begin
                pop_n = 1'b0;
                rx_gap--;
            end else begin
                pop_n = 1'b1;
                rx_gap = pick_gap(calm_rx);
                if ($urandom_range(0, 99) == 0) begin
                    calm_rx = !calm_rx;
                end
            end
        end else begin
            push_n = 1'b0;
            pop_n = 1'b0;
            wd_n = '0;
            item_n = '0;
        end
        push <= push_n;
        pop <= pop_n;
        i_cfg_we <= we_n;
        i_cfg_wdata <= wd_n;
        i_item <= item_n;
    end

    // monitor and predictor update
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            took <= 1'b0;
        end else begin
            took <= push && !full;
            if (i_cfg_we) begin
                used_cfg = i_cfg_wdata;
            end
            if (push && !full) begin
                if (i_item.mode == MODE_WRITE) begin
                    time_tbl[i_item.entry_index] = i_item.entry_time;
                    value_tbl[i_item.entry_index] = i_item.entry_value;
                    if (i_item.entry_index < 2) begin
                        span = time_tbl[1] - time_tbl[0];
                    end
                end else begin
                    expected_results.push_back(interpolate(i_item.query_time));
                end
            end
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat value=%h status=%0d", $time,
                             o_result.value, o_result.status);
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.value !== want.value) begin
                        errors++;
                        $display("%0t: value expected %h actual %h", $time,
                                 want.value, o_result.value);
                    end
                    if (o_result.status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, o_result.status);
                    end
                end
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        while (!stim_done || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #6ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
